// File: rtl/core/rrs_pkg.sv
`timescale 1ns / 1ps

package rrs_pkg;

  // Field widths fixed by the stream format.
  localparam int ID_W      = 4;
  localparam int BURST_W   = 16;
  localparam int QUANTUM_W = 16;
  localparam int TOTAL_W   = 5;
  localparam int TIME_W    = 17;
  localparam int ARRIVED_W = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Register map, decoded on paddr[2].
  localparam int  ADDR_W          = 3;
  localparam int  APB_DATA_W      = 32;
  localparam logic REG_QUANTUM    = 1'b0;
  localparam logic REG_TOTAL_JOBS = 1'b1;

  // Reset values of the registers.
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET    = 16'd500;
  localparam logic [TOTAL_W-1:0]   TOTAL_JOBS_RESET = 5'd16;

  // Saturation limit of the arrival counter.
  localparam logic [ARRIVED_W-1:0] ARRIVED_MAX = 5'd31;

  // Operation codes carried on s_tuser.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_TICK_READ,
    ST_TICK_UPDATE,
    ST_PICK_READ,
    ST_PICK_SET,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic arrive;
    logic tick_read;
    logic tick_update;
    logic pick_read;
    logic pick_set;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_pick;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/rrs_regs.sv
`timescale 1ns / 1ps

module rrs_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrs_pkg::ADDR_W-1:0]      paddr,
  input  logic [rrs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rrs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [rrs_pkg::QUANTUM_W-1:0]   quantum,
  output logic [rrs_pkg::TOTAL_W-1:0]     total_jobs
);
  import rrs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum    <= QUANTUM_RESET;
      total_jobs <= TOTAL_JOBS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_QUANTUM:    quantum    <= pwdata[QUANTUM_W-1:0];
        REG_TOTAL_JOBS: total_jobs <= pwdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (paddr[2])
      REG_QUANTUM:    prdata = APB_DATA_W'(quantum);
      REG_TOTAL_JOBS: prdata = APB_DATA_W'(total_jobs);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/rrs_ctrl.sv
`timescale 1ns / 1ps

module rrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              in_op,
  output logic              s_tready,
  input  rrs_pkg::status_t  status,
  output rrs_pkg::cmd_t     cmd
);
  import rrs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_op == OP_TICK) ? ST_TICK_READ : ST_ARRIVE;
        end
      end
      ST_ARRIVE:      state_next = ST_FINISH;
      ST_TICK_READ:   state_next = ST_TICK_UPDATE;
      ST_TICK_UPDATE: state_next = ST_PICK_READ;
      ST_PICK_READ:   state_next = status.need_pick ? ST_PICK_SET : ST_FINISH;
      ST_PICK_SET:    state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_ARRIVE:      cmd.arrive      = 1'b1;
      ST_TICK_READ:   cmd.tick_read   = 1'b1;
      ST_TICK_UPDATE: cmd.tick_update = 1'b1;
      ST_PICK_READ:   cmd.pick_read   = 1'b1;
      ST_PICK_SET:    cmd.pick_set    = 1'b1;
      ST_FINISH:      cmd.emit        = status.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/rrs_datapath.sv
`timescale 1ns / 1ps

module rrs_datapath #(
  parameter int MAX_JOBS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rrs_pkg::cmd_t                    cmd,
  output rrs_pkg::status_t                 status,
  input  logic [rrs_pkg::ID_W-1:0]         in_id,
  input  logic [rrs_pkg::BURST_W-1:0]      in_burst,
  input  logic [rrs_pkg::QUANTUM_W-1:0]    quantum,
  input  logic [rrs_pkg::TOTAL_W-1:0]      total_jobs,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [rrs_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import rrs_pkg::*;

  localparam int SLOT_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W   = $clog2(MAX_JOBS + 1);
  localparam int ID_SPAN = 1 << ID_W;

  // Job number to slot: the job number modulo the table depth.
  logic [SLOT_W-1:0] slot_lut [ID_SPAN];
  for (genvar g = 0; g < ID_SPAN; g++) begin : g_slot
    assign slot_lut[g] = SLOT_W'(g % MAX_JOBS);
  end

  // Ready queue and burst store.
  logic [SLOT_W-1:0]        qmem [MAX_JOBS];
  logic signed [TIME_W-1:0] rmem [MAX_JOBS];

  logic [SLOT_W-1:0]        q_rdata;
  logic signed [TIME_W-1:0] rem;

  // Latched input item.
  logic [SLOT_W-1:0]        arr_slot;
  logic [BURST_W-1:0]       arr_burst;

  // Scheduler state.
  logic [SLOT_W-1:0]        head;
  logic [SLOT_W-1:0]        tail;
  logic [CNT_W-1:0]         count;
  logic                     cur_valid;
  logic [SLOT_W-1:0]        cur_job;
  logic                     cur_active;
  logic signed [TIME_W-1:0] slice_left;
  logic [ARRIVED_W-1:0]     arrived;

  // Per-item result flags.
  logic                     retired;
  logic [SLOT_W-1:0]        retired_id;
  logic                     rejected;

  logic                     full;
  logic                     do_retire;
  logic                     do_requeue;
  logic                     do_run;
  logic [SLOT_W-1:0]        head_inc;
  logic [SLOT_W-1:0]        tail_inc;
  logic                     q_we;
  logic [SLOT_W-1:0]        q_wdata;
  logic                     r_we;
  logic [SLOT_W-1:0]        r_waddr;
  logic signed [TIME_W-1:0] r_wdata;
  logic                     all_done;

  assign full     = (count == CNT_W'(MAX_JOBS));
  assign head_inc = (head == SLOT_W'(MAX_JOBS - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == SLOT_W'(MAX_JOBS - 1)) ? '0 : tail + 1'b1;

  // Decisions of one tick, taken from the burst read in the previous cycle.
  assign do_retire  = cur_valid & cur_active & (rem <= $signed(TIME_W'(0)));
  assign do_requeue = ~do_retire & cur_valid & cur_active
                      & (slice_left <= $signed(TIME_W'(0)));
  assign do_run     = cur_valid & ~do_retire & ~do_requeue;

  // Memory write ports.
  always_comb begin
    q_we    = 1'b0;
    q_wdata = arr_slot;
    r_we    = 1'b0;
    r_waddr = arr_slot;
    r_wdata = $signed({1'b0, arr_burst});
    if (cmd.arrive && !full) begin
      q_we = 1'b1;
      r_we = 1'b1;
    end else if (cmd.tick_update) begin
      q_we    = do_requeue;
      q_wdata = cur_job;
      r_we    = do_run;
      r_waddr = cur_job;
      r_wdata = rem - $signed(TIME_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[tail] <= q_wdata;
    end
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
  end

  // Registered memory reads.
  always_ff @(posedge clk) begin
    if (cmd.tick_read) begin
      rem <= rmem[cur_job];
    end
    if (cmd.pick_read) begin
      q_rdata <= qmem[head];
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      arr_slot  <= slot_lut[in_id];
      arr_burst <= in_burst;
    end
  end

  // Queue pointers, running job and result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      cur_valid  <= 1'b0;
      cur_job    <= '0;
      cur_active <= 1'b0;
      slice_left <= '0;
      arrived    <= '0;
      retired    <= 1'b0;
      retired_id <= '0;
      rejected   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        retired    <= 1'b0;
        retired_id <= '0;
        rejected   <= 1'b0;
      end
      if (cmd.arrive) begin
        if (full) begin
          rejected <= 1'b1;
        end else begin
          tail  <= tail_inc;
          count <= count + 1'b1;
          if (arrived != ARRIVED_MAX) begin
            arrived <= arrived + 1'b1;
          end
        end
      end
      if (cmd.tick_update) begin
        if (do_retire) begin
          head       <= head_inc;
          count      <= count - 1'b1;
          retired    <= 1'b1;
          retired_id <= cur_job;
        end
        if (do_requeue) begin
          head       <= head_inc;
          tail       <= tail_inc;
          slice_left <= $signed({1'b0, quantum});
        end
        if (do_run) begin
          slice_left <= slice_left - $signed(TIME_W'(1));
        end
        cur_valid  <= do_run;
        cur_active <= do_run;
      end
      if (cmd.pick_set) begin
        cur_job    <= q_rdata;
        cur_valid  <= 1'b1;
        cur_active <= 1'b0;
        slice_left <= $signed({1'b0, quantum});
      end
    end
  end

  assign all_done = (arrived >= total_jobs) && (count == '0);

  // Output register; a new result loads once the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0000, rejected, all_done, ID_W'(retired_id), retired,
                  cur_valid ? ID_W'(cur_job) : ID_W'(0), cur_valid};
    end
  end

  assign status.need_pick = ~cur_valid & (count != '0);
  assign status.out_free  = ~m_tvalid | m_tready;

endmodule

// File: rtl/core/round_robin_scheduler_core.sv
// Round-robin time-slice scheduler with a FIFO ready queue.
// An arrival writes the queue and burst memories unless the queue is full; a tick reads the
// running job's burst, updates it, then reads the queue head and, when no job runs and the
// queue is not empty, makes it the running job. Items go through one at a time: a new item
// is taken only once the previous result has loaded into the output register, which waits until its result is taken.
// Reset (rst, synchronous) empties the queue, idles the scheduler and loads default registers.
`timescale 1ns / 1ps

module round_robin_scheduler_core #(
  parameter int MAX_JOBS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Item stream in.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [3:0] arrive_id, [19:4] arrive_burst, [23:20] zero
  input  logic [rrs_pkg::IN_DATA_W-1:0]   s_tdata,
  // [0] operation
  input  logic                            s_tuser,
  // Result stream out.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] run_valid, [4:1] run_id, [5] retired_valid, [9:6] retired_id,
  // [10] all_done, [11] arrive_rejected, [15:12] zero
  output logic [rrs_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrs_pkg::ADDR_W-1:0]      paddr,
  input  logic [rrs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rrs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rrs_pkg::*;

  cmd_t                   cmd;
  status_t                status;
  logic [QUANTUM_W-1:0]   quantum;
  logic [TOTAL_W-1:0]     total_jobs;

  rrs_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .quantum    (quantum),
    .total_jobs (total_jobs)
  );

  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_op    (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rrs_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_id      (s_tdata[ID_W-1:0]),
    .in_burst   (s_tdata[ID_W+BURST_W-1:ID_W]),
    .quantum    (quantum),
    .total_jobs (total_jobs),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rrs_pkg::*;

  // One input item and one result item of the scheduler.
  typedef struct packed {
    logic                op;
    logic [ID_W-1:0]     id;
    logic [BURST_W-1:0]  burst;
  } sched_item_t;

  typedef struct packed {
    logic            run_valid;
    logic [ID_W-1:0] run_id;
    logic            retired_valid;
    logic [ID_W-1:0] retired_id;
    logic            all_done;
    logic            arrive_rejected;
  } sched_out_t;

  localparam int JOBS            = 16;
  localparam int ITEMS_PER_PHASE = 125;
  localparam logic [ADDR_W-1:0] ADDR_QUANTUM = {REG_QUANTUM, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_TOTAL   = {REG_TOTAL_JOBS, 2'b00};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_W-1:0]     s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]    m_tdata;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [APB_DATA_W-1:0]    pwdata = '0;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  round_robin_scheduler_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Items waiting to be sent and scheduler outputs waiting to come back.
  sched_item_t pending[$];
  sched_out_t  sched_expect[$];
  sched_item_t held;
  int          issued   = 0;
  int          accepted = 0;
  int          errors   = 0;
  logic        send_gaps  = 1'b0;
  logic        recv_stalls = 1'b0;
  int          idle_pct   = 46;

  // Scheduler state mirrored by the predictor.
  logic [ID_W-1:0]      rq_slots[JOBS];
  logic [ID_W-1:0]      rq_head = '0;
  logic [ID_W-1:0]      rq_tail = '0;
  int                   rq_count = 0;
  int                   job_left[JOBS];
  logic                 run_on = 1'b0;
  logic [ID_W-1:0]      run_job = '0;
  logic                 run_live = 1'b0;
  int                   slice_cnt = 0;
  int                   arrivals = 0;
  int                   cfg_quantum = int'(QUANTUM_RESET);
  int                   cfg_total = int'(TOTAL_JOBS_RESET);

  function automatic void ready_push(logic [ID_W-1:0] id);
    rq_slots[rq_tail] = id;
    rq_tail = rq_tail + 1'b1;
    rq_count++;
  endfunction

  function automatic void ready_pop();
    if (rq_count > 0) begin
      rq_head = rq_head + 1'b1;
      rq_count--;
    end
  endfunction

  // Advance the mirrored scheduler by one item and return what it reports.
  function automatic sched_out_t schedule_step(sched_item_t it);
    sched_out_t      r;
    logic [ID_W-1:0] cur;
    r = '0;
    if (it.op == OP_ARRIVE) begin
      if (rq_count >= JOBS) begin
        r.arrive_rejected = 1'b1;
      end else begin
        ready_push(it.id);
        job_left[it.id] = int'(it.burst);
        if (arrivals < int'(ARRIVED_MAX)) arrivals++;
      end
    end else begin
      cur = run_job;
      // A job retires only after it has run with its burst used up.
      if (run_on && run_live && job_left[cur] <= 0) begin
        ready_pop();
        r.retired_valid = 1'b1;
        r.retired_id = cur;
        run_on = 1'b0;
        run_live = 1'b0;
      end
      // Slice expired: the job goes back to the tail.
      if (slice_cnt <= 0 && run_on && run_live) begin
        run_live = 1'b0;
        ready_pop();
        ready_push(cur);
        slice_cnt = cfg_quantum;
        run_on = 1'b0;
      end
      if (run_on && !run_live) run_live = 1'b1;
      if (run_on && run_live) begin
        job_left[cur]--;
        slice_cnt--;
      end
      if (!run_on && rq_count > 0) begin
        run_job = rq_slots[rq_head];
        run_on = 1'b1;
        run_live = 1'b0;
        slice_cnt = cfg_quantum;
      end
    end
    r.run_valid = run_on;
    r.run_id = run_on ? run_job : '0;
    r.all_done = (arrivals >= cfg_total) && (rq_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Driver: present queued items and predict each one at its transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        sched_expect.push_back(schedule_step(held));
        accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && !(send_gaps && $urandom_range(99) < idle_pct)) begin
          held = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'd0, held.burst, held.id};
          s_tuser <= held.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    sched_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sched_expect.size() == 0) begin
          report_mismatch("unexpected result, tdata", int'(m_tdata), 0);
        end else begin
          want = sched_expect.pop_front();
          if (m_tdata[0] !== want.run_valid)
            report_mismatch("run_valid", int'(m_tdata[0]), int'(want.run_valid));
          if (m_tdata[4:1] !== want.run_id)
            report_mismatch("run_id", int'(m_tdata[4:1]), int'(want.run_id));
          if (m_tdata[5] !== want.retired_valid)
            report_mismatch("retired_valid", int'(m_tdata[5]), int'(want.retired_valid));
          if (m_tdata[9:6] !== want.retired_id)
            report_mismatch("retired_id", int'(m_tdata[9:6]), int'(want.retired_id));
          if (m_tdata[10] !== want.all_done)
            report_mismatch("all_done", int'(m_tdata[10]), int'(want.all_done));
          if (m_tdata[11] !== want.arrive_rejected)
            report_mismatch("arrive_rejected", int'(m_tdata[11]), int'(want.arrive_rejected));
        end
      end
      m_tready <= recv_stalls ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end
  end

  task automatic add_item(logic op, int id, int burst);
    sched_item_t it;
    it.op = op;
    it.id = id[ID_W-1:0];
    it.burst = burst[BURST_W-1:0];
    pending.push_back(it);
    issued++;
  endtask

  function automatic int pick_burst();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 95) return $urandom_range(0, 200);
    return $urandom_range(0, 65535);
  endfunction

  // One stretch of random traffic: mostly job sets that then get time to
  // run, some floods that fill the queue, and some loose noise.
  task automatic add_episode();
    int kind;
    kind = $urandom_range(99);
    if (kind < 75) begin
      repeat ($urandom_range(1, 6)) begin
        add_item(OP_ARRIVE, $urandom_range(0, JOBS - 1), pick_burst());
        repeat ($urandom_range(0, 3)) add_item(OP_TICK, $urandom_range(0, 15), 0);
      end
      repeat ($urandom_range(4, 40)) add_item(OP_TICK, $urandom_range(0, 15), $urandom);
    end else if (kind < 85) begin
      repeat ($urandom_range(14, 20))
        add_item(OP_ARRIVE, $urandom_range(0, JOBS - 1), $urandom_range(0, 8));
      repeat ($urandom_range(10, 40)) add_item(OP_TICK, 0, 0);
    end else begin
      repeat ($urandom_range(1, 10))
        add_item(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                 ($urandom_range(9) < 3) ? $urandom_range(0, 65535) : $urandom_range(0, 30));
    end
  endtask

  // Wait until every item has gone in and every result has come out.
  task automatic wait_drained();
    while (accepted != issued || sched_expect.size() != 0) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic [ADDR_W-1:0] addr, int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_QUANTUM) cfg_quantum = value & 16'hFFFF;
    else cfg_total = value & 5'h1F;
  endtask

  initial begin
    int quanta[8];
    int totals[8];
    int target;
    quanta = '{500, 0, 1, 3, 2, 7, 4, 65535};
    totals = '{16, 0, 1, 16, 31, 5, 12, 31};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: empty tick, zero burst,
    // full-range fields, overwrite of a running job and a queued duplicate.
    add_item(OP_TICK, 0, 0);
    add_item(OP_ARRIVE, 0, 0);
    repeat (3) add_item(OP_TICK, 0, 0);
    add_item(OP_ARRIVE, 15, 65535);
    add_item(OP_ARRIVE, 10, 1);
    repeat (2) add_item(OP_TICK, 15, 65535);
    add_item(OP_ARRIVE, 15, 2);
    add_item(OP_ARRIVE, 5, 16'hAAAA);
    add_item(OP_ARRIVE, 5, 16'h5555);
    add_item(OP_ARRIVE, 5, 1);
    repeat (12) add_item(OP_TICK, 10, 16'h5555);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        wait_drained();
        repeat (8) @(posedge clk);
        write_reg(ADDR_QUANTUM, quanta[ph]);
        write_reg(ADDR_TOTAL, totals[ph]);
      end
      send_gaps = (ph % 4 == 1) || (ph % 4 == 3);
      recv_stalls = (ph % 4 == 2) || (ph % 4 == 3);
      // With both sides idling, each holds back about 22 percent of the time.
      idle_pct = (send_gaps && recv_stalls) ? 22 : 46;
      target = issued + ITEMS_PER_PHASE;
      while (issued < target) add_episode();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sched_expect.size() != 0)
      report_mismatch("results missing", 0, sched_expect.size());
    if (errors == 0) begin
      $display("[round_robin_scheduler_core] OK");
    end else begin
      $display("[round_robin_scheduler_core] ERROR");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #5_000_000;
    $display("[round_robin_scheduler_core] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rrs_pkg.sv
rtl/core/rrs_regs.sv
rtl/core/rrs_ctrl.sv
rtl/core/rrs_datapath.sv
rtl/core/round_robin_scheduler_core.sv
bench/tb.sv
